// ===== hw/rtl/csx_pkg.sv =====
`timescale 1ns / 1ps

package csx_pkg;

   // Fraction bits of the fixed-point value (Q.FRAC_BITS)
   localparam int FRAC_BITS = 16;

   // Width of the signed shift amount that is applied to a decoded magnitude
   localparam int KW = 12;

   typedef logic signed [KW-1:0] shamt_type;

   // Shift amounts: exponent offset plus fraction bits
   localparam shamt_type K_INT     = KW'(FRAC_BITS);
   localparam shamt_type K_F32_SUB = KW'(FRAC_BITS - 149);
   localparam shamt_type K_F32_NRM = KW'(FRAC_BITS - 150);
   localparam shamt_type K_F64_SUB = KW'(FRAC_BITS - 1074);
   localparam shamt_type K_F64_NRM = KW'(FRAC_BITS - 1075);

   localparam logic [95:0] FRAC_MASK = (96'(1) << FRAC_BITS) - 96'(1);

   typedef enum logic [1:0] {
      SIG_UNSIGNED = 2'd0,
      SIG_SIGNED   = 2'd1,
      SIG_FLOAT32  = 2'd2,
      SIG_FLOAT64  = 2'd3
   } sig_kind_type;

   typedef enum logic [2:0] {
      REG_FRAME_ID     = 3'd0,
      REG_START_BIT    = 3'd1,
      REG_BIT_LENGTH   = 3'd2,
      REG_SIGNAL_TYPE  = 3'd3,
      REG_CLAMP_MIN    = 3'd4,
      REG_CLAMP_MAX    = 3'd5,
      REG_SCALE_FACTOR = 3'd6,
      REG_SCALE_OFFSET = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [28:0]        frame_id;
      logic [5:0]         start_bit;
      logic [6:0]         bit_length;
      sig_kind_type       signal_type;
      logic signed [63:0] clamp_min;
      logic signed [63:0] clamp_max;
      logic signed [31:0] scale_factor;
      logic signed [63:0] scale_offset;
   } cfg_type;

   // Decoded field: sign, magnitude and shift to reach Q.FRAC_BITS
   typedef struct packed {
      logic        valid;
      logic        neg;
      logic        force_zero;
      logic        force_sat;
      logic [63:0] mag;
      shamt_type   k;
   } dec_type;

   typedef struct packed {
      logic               valid;
      logic signed [63:0] value;
   } fix_type;

endpackage

// ===== hw/rtl/can_signal_extract_scale.sv =====
`timescale 1ns / 1ps

// CAN signal decoder. A frame is taken on every clock edge where start is high;
// busy is never raised, so frames may arrive back to back, one per cycle. A
// frame whose identifier equals frame_id yields exactly one result: rsp_strobe
// is high for one cycle, with rsp_value holding the scaled Q47.16 value. Any
// other frame yields nothing. The receiver must take every strobed result;
// there is no hold-off. The ten register stages are: extract, decode,
// float/int to fixed, clamp, magnitudes, two 32x32 partial products, product
// sum, rounding, saturation, offset add. Write csr_* only while no frame is in
// flight.
module can_signal_extract_scale (
   input  logic        clock,
   input  logic        reset,
   // frame input
   input  logic        start,
   output logic        busy,
   input  logic [28:0] req_can_id,
   input  logic [63:0] req_payload,
   // result output
   output logic        rsp_strobe,
   output logic [63:0] rsp_value,
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   csx_pkg::cfg_type cfg_ff, cfg_in;
   csx_pkg::dec_type dec;
   csx_pkg::fix_type fix;

   // Pipeline never stalls: every start is a transfer.
   assign busy = 1'b0;

   // Register file; writes are masked to each register's width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csx_pkg::reg_index_type'(csr_index))
            csx_pkg::REG_FRAME_ID:     cfg_in.frame_id     = csr_wdata[28:0];
            csx_pkg::REG_START_BIT:    cfg_in.start_bit    = csr_wdata[5:0];
            csx_pkg::REG_BIT_LENGTH:   cfg_in.bit_length   = csr_wdata[6:0];
            csx_pkg::REG_SIGNAL_TYPE:
               cfg_in.signal_type = csx_pkg::sig_kind_type'(csr_wdata[1:0]);
            csx_pkg::REG_CLAMP_MIN:    cfg_in.clamp_min    = csr_wdata;
            csx_pkg::REG_CLAMP_MAX:    cfg_in.clamp_max    = csr_wdata;
            csx_pkg::REG_SCALE_FACTOR: cfg_in.scale_factor = csr_wdata[31:0];
            csx_pkg::REG_SCALE_OFFSET: cfg_in.scale_offset = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_id     <= 29'd0;
         cfg_ff.start_bit    <= 6'd0;
         cfg_ff.bit_length   <= 7'd8;
         cfg_ff.signal_type  <= csx_pkg::SIG_UNSIGNED;
         cfg_ff.clamp_min    <= {1'b1, 63'd0};          // most negative
         cfg_ff.clamp_max    <= {1'b0, {63{1'b1}}};     // most positive
         cfg_ff.scale_factor <= 32'sd65536;             // 1.0 in Q15.16
         cfg_ff.scale_offset <= 64'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stages 1-2: id match, field extract, type decode
   csx_extract u_extract (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .take        (start),
      .req_can_id  (req_can_id),
      .req_payload (req_payload),
      .dec         (dec)
   );

   // stage 3: conversion to signed Q.16, saturating
   csx_to_fixed u_to_fixed (
      .clock (clock),
      .reset (reset),
      .dec   (dec),
      .fix   (fix)
   );

   // stages 4-10: clamp, multiply, round toward minus infinity, offset
   csx_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fix        (fix),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value)
   );

endmodule

// ===== hw/rtl/csx_extract.sv =====
`timescale 1ns / 1ps

// Identifier match and field extraction, then per-type decode.
module csx_extract (
   input  logic             clock,
   input  logic             reset,
   input  csx_pkg::cfg_type cfg,
   input  logic             take,
   input  logic [28:0]      req_can_id,
   input  logic [63:0]      req_payload,
   output csx_pkg::dec_type dec
);

   // stage 1: extract
   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_field_ff, s1_field_in;
   logic [63:0] s1_sext_ff, s1_sext_in;
   logic        s1_sign_ff, s1_sign_in;

   logic [6:0]  len;
   logic [6:0]  len_m1;
   logic [63:0] mask;
   logic [63:0] shifted;

   always_comb begin
      len     = (cfg.bit_length > 7'd64) ? 7'd64 : cfg.bit_length;
      len_m1  = len - 7'd1;
      mask    = (len == 7'd64) ? {64{1'b1}} : ((64'(1) << len[5:0]) - 64'(1));
      shifted = req_payload >> cfg.start_bit;
      s1_valid_in = take && (req_can_id == cfg.frame_id);
      s1_field_in = shifted & mask;
      s1_sign_in  = (len != 7'd0) && shifted[len_m1[5:0]];
      s1_sext_in  = s1_sign_in ? (s1_field_in | ~mask) : s1_field_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_field_ff <= s1_field_in;
      s1_sext_ff  <= s1_sext_in;
      s1_sign_ff  <= s1_sign_in;
   end

   // stage 2: decode
   csx_pkg::dec_type dec_ff, dec_in;

   always_comb begin
      dec_in            = '0;
      dec_in.valid      = s1_valid_ff;
      dec_in.k          = csx_pkg::K_INT;
      dec_in.mag        = s1_field_ff;
      case (cfg.signal_type)
         csx_pkg::SIG_UNSIGNED: begin
            dec_in.mag = s1_field_ff;
         end
         csx_pkg::SIG_SIGNED: begin
            dec_in.neg = s1_sign_ff;
            dec_in.mag = s1_sign_ff ? (~s1_sext_ff + 64'(1)) : s1_sext_ff;
         end
         csx_pkg::SIG_FLOAT32: begin
            dec_in.neg = s1_field_ff[31];
            if (s1_field_ff[30:23] == 8'hFF) begin
               dec_in.force_zero = (s1_field_ff[22:0] != 23'd0);
               dec_in.force_sat  = (s1_field_ff[22:0] == 23'd0);
            end else if (s1_field_ff[30:23] == 8'd0) begin
               dec_in.mag = {41'd0, s1_field_ff[22:0]};
               dec_in.k   = csx_pkg::K_F32_SUB;
            end else begin
               dec_in.mag = {40'd0, 1'b1, s1_field_ff[22:0]};
               dec_in.k   = csx_pkg::shamt_type'({4'd0, s1_field_ff[30:23]})
                            + csx_pkg::K_F32_NRM;
            end
         end
         default: begin
            dec_in.neg = s1_field_ff[63];
            if (s1_field_ff[62:52] == 11'h7FF) begin
               dec_in.force_zero = (s1_field_ff[51:0] != 52'd0);
               dec_in.force_sat  = (s1_field_ff[51:0] == 52'd0);
            end else if (s1_field_ff[62:52] == 11'd0) begin
               dec_in.mag = {12'd0, s1_field_ff[51:0]};
               dec_in.k   = csx_pkg::K_F64_SUB;
            end else begin
               dec_in.mag = {11'd0, 1'b1, s1_field_ff[51:0]};
               dec_in.k   = csx_pkg::shamt_type'({1'b0, s1_field_ff[62:52]})
                            + csx_pkg::K_F64_NRM;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid <= 1'b0;
      end else begin
         dec_ff.valid <= dec_in.valid;
      end
      dec_ff.neg        <= dec_in.neg;
      dec_ff.force_zero <= dec_in.force_zero;
      dec_ff.force_sat  <= dec_in.force_sat;
      dec_ff.mag        <= dec_in.mag;
      dec_ff.k          <= dec_in.k;
   end

   assign dec = dec_ff;

endmodule

// ===== hw/rtl/csx_to_fixed.sv =====
`timescale 1ns / 1ps

// Sign/magnitude times 2^k to signed 64-bit fixed point, saturating.
module csx_to_fixed (
   input  logic             clock,
   input  logic             reset,
   input  csx_pkg::dec_type dec,
   output csx_pkg::fix_type fix
);

   csx_pkg::fix_type fix_ff, fix_in;

   logic [63:0]         lim;
   logic [127:0]        wide;
   csx_pkg::shamt_type  nk;
   logic [63:0]         mag_out;

   always_comb begin
      lim  = {dec.neg, {63{~dec.neg}}};
      wide = {64'd0, dec.mag} << dec.k[5:0];
      nk   = -dec.k;
      if (dec.force_zero || dec.mag == 64'd0) begin
         mag_out = 64'd0;
      end else if (dec.force_sat) begin
         mag_out = lim;
      end else if (!dec.k[csx_pkg::KW-1]) begin
         if (dec.k > csx_pkg::shamt_type'(63)) begin
            mag_out = lim;
         end else if (wide[127:64] != 64'd0 || wide[63:0] > lim) begin
            mag_out = lim;
         end else begin
            mag_out = wide[63:0];
         end
      end else if (nk > csx_pkg::shamt_type'(63)) begin
         mag_out = 64'd0;
      end else begin
         mag_out = dec.mag >> nk[5:0];
      end
      fix_in.valid = dec.valid;
      fix_in.value = dec.neg ? $signed(~mag_out + 64'(1)) : $signed(mag_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff.valid <= 1'b0;
      end else begin
         fix_ff.valid <= fix_in.valid;
      end
      fix_ff.value <= fix_in.value;
   end

   assign fix = fix_ff;

endmodule

// ===== hw/rtl/csx_scale.sv =====
`timescale 1ns / 1ps

// Clamp, Q15.16 multiply with floor rounding, saturating offset add.
module csx_scale (
   input  logic             clock,
   input  logic             reset,
   input  csx_pkg::cfg_type cfg,
   input  csx_pkg::fix_type fix,
   output logic             rsp_strobe,
   output logic [63:0]      rsp_value
);

   // valid bits, one per stage
   logic [6:0] vld_ff, vld_in;

   // clamp: max first, then min
   logic signed [63:0] cl_ff, cl_in, c_hi;

   // magnitudes and product sign
   logic [63:0] mv_ff, mv_in;
   logic [31:0] mf_ff, mf_in;
   logic        ng_ff, ng_in;

   // partial products
   logic [63:0] plo_ff, plo_in, phi_ff, phi_in;
   logic        ng2_ff;

   // full product
   logic [95:0] prod_ff, prod_in;
   logic        ng3_ff;

   // shifted, floor-corrected magnitude
   logic [95:0] q_ff, q_in;
   logic        ng4_ff;

   // saturated signed product
   logic signed [63:0] sc_ff, sc_in;
   logic [63:0]        lim, qmag;

   // offset add
   logic [63:0] out_ff, out_in, sum;

   always_comb begin
      vld_in = {vld_ff[5:0], fix.valid};

      c_hi  = (fix.value > cfg.clamp_max) ? cfg.clamp_max : fix.value;
      cl_in = (c_hi < cfg.clamp_min) ? cfg.clamp_min : c_hi;

      mv_in = cl_ff[63] ? (~cl_ff + 64'(1)) : cl_ff;
      mf_in = cfg.scale_factor[31] ? (~cfg.scale_factor + 32'(1)) : cfg.scale_factor;
      ng_in = cl_ff[63] ^ cfg.scale_factor[31];

      plo_in = 64'(mv_ff[31:0]) * 64'(mf_ff);
      phi_in = 64'(mv_ff[63:32]) * 64'(mf_ff);

      prod_in = {32'd0, plo_ff} + {phi_ff, 32'd0};

      q_in = (prod_ff >> csx_pkg::FRAC_BITS)
             + 96'(ng3_ff && ((prod_ff & csx_pkg::FRAC_MASK) != 96'd0));

      lim   = {ng4_ff, {63{~ng4_ff}}};
      qmag  = (q_ff > {32'd0, lim}) ? lim : q_ff[63:0];
      sc_in = ng4_ff ? $signed(~qmag + 64'(1)) : $signed(qmag);

      sum = sc_ff + cfg.scale_offset;
      if (!sc_ff[63] && !cfg.scale_offset[63] && sum[63]) begin
         out_in = {1'b0, {63{1'b1}}};
      end else if (sc_ff[63] && cfg.scale_offset[63] && !sum[63]) begin
         out_in = {1'b1, 63'd0};
      end else begin
         out_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cl_ff   <= cl_in;
      mv_ff   <= mv_in;
      mf_ff   <= mf_in;
      ng_ff   <= ng_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      ng2_ff  <= ng_ff;
      prod_ff <= prod_in;
      ng3_ff  <= ng2_ff;
      q_ff    <= q_in;
      ng4_ff  <= ng3_ff;
      sc_ff   <= sc_in;
      out_ff  <= out_in;
   end

   assign rsp_strobe = vld_ff[6];
   assign rsp_value  = out_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import csx_pkg::*;

   // Signed 64-bit rails of the Q47.16 value
   localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

   // Settle time for frames still in the pipeline; leave some margin
   localparam int SETTLE_CYCLES = 16;
   // Cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT   = 5000;
   localparam int GROUPS        = 34;
   localparam int GROUP_ITEMS   = 25;

   // Local copy of the decoder's register file
   typedef struct packed {
      logic [28:0]        frame_id;
      logic [5:0]         start_bit;
      logic [6:0]         bit_length;
      sig_kind_type       kind;
      logic signed [63:0] clamp_min;
      logic signed [63:0] clamp_max;
      logic signed [31:0] factor;
      logic signed [63:0] offset;
   } decoder_cfg_t;

   localparam decoder_cfg_t CFG_RESET = '{
      frame_id: 29'd0, start_bit: 6'd0, bit_length: 7'd8, kind: SIG_UNSIGNED,
      clamp_min: SMIN, clamp_max: SMAX, factor: 32'sd65536, offset: 64'sd0};

   // How a directed row is checked
   typedef enum logic [1:0] {
      CHECK_PREDICT,   // run through the predictor
      CHECK_VALUE,     // fixed value typed into the row
      CHECK_SILENT     // frame must produce nothing
   } row_check_t;

   typedef struct {
      decoder_cfg_t c;
      logic [28:0]  id;
      logic [63:0]  pl;
      row_check_t   check;
      logic [63:0]  want;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [28:0] req_can_id;
   logic [63:0] req_payload;
   logic        rsp_strobe;
   logic [63:0] rsp_value;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   decoder_cfg_t active_cfg = CFG_RESET;
   logic [63:0]  pending_values[$];   // predicted values, oldest first
   stim_row_t    rows[$];
   int           mismatches = 0;
   int           stall_cycles = 0;
   int           gap_pct = 0;         // chance (percent) of an idle cycle before a frame

   can_signal_extract_scale u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_can_id  (req_can_id),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_value   (rsp_value),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // sign/magnitude times 2^e into Q.16, saturated to the side of the sign
   function automatic logic signed [63:0] fix_from_mag(input logic neg,
                                                       input logic [63:0] mag,
                                                       input int e);
      int          k;
      logic [63:0] lim;
      logic [63:0] v;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      k = e + FRAC_BITS;
      if (k >= 0) begin
         if (mag == 64'd0) v = 64'd0;
         else if (k >= 64) v = lim;
         else if (mag > (lim >> k)) v = lim;
         else v = mag << k;
      end else begin
         v = (-k >= 64) ? 64'd0 : (mag >> (-k));
      end
      return neg ? -v : v;
   endfunction

   // IEEE pattern to Q.16: truncate toward zero, NaN -> 0, inf saturates
   function automatic logic signed [63:0] fix_from_float(input logic [63:0] bits,
                                                         input int mbits,
                                                         input int ebits,
                                                         input int bias);
      logic [63:0] frac;
      logic [63:0] emax;
      logic [63:0] ex;
      logic        neg;
      frac = bits & ((64'd1 << mbits) - 64'd1);
      emax = (64'd1 << ebits) - 64'd1;
      ex   = (bits >> mbits) & emax;
      neg  = bits[mbits + ebits];
      if (ex == emax) begin
         if (frac != 64'd0) return 64'sd0;
         return neg ? SMIN : SMAX;
      end
      if (ex == 64'd0) return fix_from_mag(neg, frac, 1 - bias - mbits);
      return fix_from_mag(neg, frac | (64'd1 << mbits), int'(ex) - bias - mbits);
   endfunction

   // Full decode of one matching frame: extract, convert, clamp, scale, offset
   function automatic logic signed [63:0] scaled_value(input logic [63:0] pl,
                                                       input decoder_cfg_t c);
      int                  len;
      logic [63:0]         mask;
      logic [63:0]         field;
      logic [63:0]         full;
      logic signed [63:0]  v;
      logic signed [127:0] prod;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      logic signed [64:0]  acc;
      len   = (c.bit_length > 7'd64) ? 64 : int'(c.bit_length);
      mask  = (len == 64) ? {64{1'b1}} : ((64'd1 << len) - 64'd1);
      field = (pl >> c.start_bit) & mask;
      case (c.kind)
         SIG_UNSIGNED: v = fix_from_mag(1'b0, field, 0);
         SIG_SIGNED: begin
            if (len != 0 && field[len-1]) begin
               full = field | ~mask;
               v = fix_from_mag(1'b1, ~full + 64'd1, 0);
            end else begin
               v = fix_from_mag(1'b0, field, 0);
            end
         end
         SIG_FLOAT32: v = fix_from_float(field & 64'hFFFF_FFFF, 23, 8, 127);
         default:     v = fix_from_float(field, 52, 11, 1023);
      endcase
      // max first, so crossed limits end on clamp_min
      if (v > c.clamp_max) v = c.clamp_max;
      if (v < c.clamp_min) v = c.clamp_min;
      // exact product, arithmetic shift rounds toward minus infinity
      prod   = v * c.factor;
      prod   = prod >>> FRAC_BITS;
      hi_lim = SMAX;
      lo_lim = SMIN;
      if (prod > hi_lim) v = SMAX;
      else if (prod < lo_lim) v = SMIN;
      else v = prod[63:0];
      acc = v + c.offset;
      if (acc[64] != acc[63]) v = acc[64] ? SMIN : SMAX;
      else v = acc[63:0];
      return v;
   endfunction

   function automatic void predict_frame(input logic [28:0] id, input logic [63:0] pl);
      if (id == active_cfg.frame_id) pending_values.push_back(scaled_value(pl, active_cfg));
   endfunction

   function automatic void add_row(input decoder_cfg_t c, input logic [28:0] id,
                                   input logic [63:0] pl, input row_check_t check,
                                   input logic [63:0] want);
      stim_row_t r;
      r.c = c;
      r.id = id;
      r.pl = pl;
      r.check = check;
      r.want = want;
      rows.push_back(r);
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic csr_write(input reg_index_type idx, input logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write all eight registers; junk goes into the bits above each field
   task automatic load_cfg(input decoder_cfg_t c, input logic junk);
      logic [63:0] filler;
      filler = junk ? {$urandom, $urandom} : 64'd0;
      csr_write(REG_FRAME_ID,     {filler[63:29], c.frame_id});
      csr_write(REG_START_BIT,    {filler[63:6], c.start_bit});
      csr_write(REG_BIT_LENGTH,   {filler[63:7], c.bit_length});
      csr_write(REG_SIGNAL_TYPE,  {filler[63:2], c.kind});
      csr_write(REG_CLAMP_MIN,    c.clamp_min);
      csr_write(REG_CLAMP_MAX,    c.clamp_max);
      csr_write(REG_SCALE_FACTOR, {filler[63:32], c.factor});
      csr_write(REG_SCALE_OFFSET, c.offset);
      @(posedge clock);
      csr_we <= 1'b0;
      active_cfg = c;
   endtask

   // One frame transfer; start stays high on return so frames can go back to back
   task automatic send_frame(input logic [28:0] id, input logic [63:0] pl);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_can_id  <= id;
      req_payload <= pl;
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every predicted value is back, then let silent frames flush
   task automatic drain_results();
      start <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < 40)
         $display("%0t ns  %s: got %h, predicted %h", $time, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- checking

   // Results cannot be held off: every strobe is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_values.size() == 0) begin
            report_mismatch("result with no frame pending", rsp_value, 64'd0);
         end else if (rsp_value !== pending_values[0]) begin
            report_mismatch("value mismatch", rsp_value, pending_values.pop_front());
         end else begin
            void'(pending_values.pop_front());
         end
      end
   end

   // Hang detection: any frame, result or register transfer resets the count
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || csr_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      decoder_cfg_t       c;
      logic [28:0]        id;
      logic [63:0]        pl;
      logic [63:0]        fld;
      logic [51:0]        frac;
      logic [7:0]         ex_f32;
      logic [10:0]        ex_f64;
      logic               sgn;
      logic signed [63:0] a;
      logic signed [63:0] b;

      reset       = 1'b1;
      start       = 1'b0;
      req_can_id  = '0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;

      // Directed table. Rows in reset config run before any register write.
      c = CFG_RESET;
      add_row(c, 29'd0, 64'hFFFF_FFFF_FFFF_FFAB, CHECK_VALUE, 64'h0000_0000_00AB_0000);
      add_row(c, 29'd1, 64'h0123_4567_89AB_CDEF, CHECK_SILENT, 64'd0);
      c.bit_length = 7'd64;                              // all ones saturates high
      add_row(c, 29'd0, {64{1'b1}}, CHECK_VALUE, SMAX);
      c.kind = SIG_SIGNED;
      add_row(c, 29'd0, 64'h8000_0000_0000_0000, CHECK_VALUE, SMIN);
      c.bit_length = 7'd8;
      add_row(c, 29'd0, 64'h0000_0000_0000_00FF, CHECK_VALUE, 64'hFFFF_FFFF_FFFF_0000);
      c.bit_length = 7'd0;                               // empty field reads as zero
      add_row(c, 29'd0, {64{1'b1}}, CHECK_VALUE, 64'd0);
      c.kind       = SIG_UNSIGNED;                       // overlong length acts as 64
      c.bit_length = 7'd100;
      c.start_bit  = 6'd63;
      c.frame_id   = 29'h1FFF_FFFF;
      add_row(c, 29'h1FFF_FFFF, 64'h8000_0000_0000_0000, CHECK_VALUE, 64'h1_0000);
      add_row(c, 29'h1FFF_FFFE, {64{1'b1}}, CHECK_SILENT, 64'd0);
      c = CFG_RESET;
      c.kind       = SIG_FLOAT32;
      c.bit_length = 7'd32;
      add_row(c, 29'd0, 64'hDEAD_BEEF_3F80_0000, CHECK_VALUE, 64'h1_0000);
      add_row(c, 29'd0, 64'h7FC0_0000, CHECK_VALUE, 64'd0);              // NaN
      add_row(c, 29'd0, 64'h7F80_0000, CHECK_VALUE, SMAX);               // +inf
      add_row(c, 29'd0, 64'hFF80_0000, CHECK_VALUE, SMIN);               // -inf
      add_row(c, 29'd0, 64'h0000_0001, CHECK_VALUE, 64'd0);              // subnormal
      add_row(c, 29'd0, 64'hBFC0_0000, CHECK_VALUE, 64'hFFFF_FFFF_FFFE_8000);
      c.kind       = SIG_FLOAT64;
      c.bit_length = 7'd64;
      add_row(c, 29'd0, 64'h3FF0_0000_0000_0000, CHECK_VALUE, 64'h1_0000);
      add_row(c, 29'd0, 64'h4630_0000_0000_0000, CHECK_VALUE, SMAX);     // 2^100
      add_row(c, 29'd0, 64'h7FF8_0000_0000_0000, CHECK_VALUE, 64'd0);    // NaN
      c = CFG_RESET;                                     // crossed clamps
      c.clamp_min = 64'sh10_0000;
      c.clamp_max = 64'sh1_0000;
      add_row(c, 29'd0, 64'h05, CHECK_VALUE, 64'h10_0000);
      c = CFG_RESET;                                     // -1.5 LSB floors to -2
      c.kind       = SIG_FLOAT32;
      c.bit_length = 7'd32;
      c.factor     = 32'sd1;
      add_row(c, 29'd0, 64'hBFC0_0000, CHECK_VALUE, 64'hFFFF_FFFF_FFFF_FFFE);
      c = CFG_RESET;
      c.bit_length = 7'd64;
      c.factor     = 32'sh8000_0000;
      add_row(c, 29'd0, {64{1'b1}}, CHECK_VALUE, SMIN);
      c.bit_length = 7'd8;
      c.factor     = 32'sh7FFF_FFFF;
      c.offset     = 64'sh1_0000;
      add_row(c, 29'd0, 64'h01, CHECK_VALUE, 64'h0000_0000_8000_FFFF);
      c.bit_length = 7'd64;                              // offset add saturates
      c.factor     = 32'sd65536;
      c.offset     = SMAX;
      add_row(c, 29'd0, {64{1'b1}}, CHECK_VALUE, SMAX);
      c.kind   = SIG_SIGNED;
      c.offset = SMIN;
      add_row(c, 29'd0, 64'h8000_0000_0000_0000, CHECK_VALUE, SMIN);
      c = CFG_RESET;
      c.kind       = SIG_SIGNED;
      c.start_bit  = 6'd13;
      c.bit_length = 7'd21;
      c.factor     = -32'sd70000;
      c.offset     = 64'sh123_4567;
      c.clamp_min  = -64'sh40_0000_0000;
      c.clamp_max  = 64'sh3_0000_0000;
      add_row(c, 29'd0, 64'hA5C3_0F96_7E21_B4D8, CHECK_PREDICT, 64'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].c !== active_cfg) begin
            drain_results();
            load_cfg(rows[i].c, 1'b0);
         end
         send_frame(rows[i].id, rows[i].pl);
         case (rows[i].check)
            CHECK_PREDICT: predict_frame(rows[i].id, rows[i].pl);
            CHECK_VALUE:   pending_values.push_back(rows[i].want);
            default: ;
         endcase
      end

      // Random groups: new register set per group, then back-to-back frames.
      // Sender gaps: 16% for the first third, 65% for the second, none after.
      for (int g = 0; g < GROUPS; g++) begin
         gap_pct = (g < 11) ? 16 : (g < 22) ? 65 : 0;

         c = CFG_RESET;
         c.kind = sig_kind_type'($urandom_range(3));
         case ($urandom_range(3))
            0:       c.frame_id = '0;
            1:       c.frame_id = '1;
            default: c.frame_id = 29'($urandom);
         endcase
         case (c.kind)
            SIG_FLOAT32: begin
               c.start_bit  = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(32));
               c.bit_length = ($urandom_range(4) == 0) ? 7'($urandom) : 7'd32;
            end
            SIG_FLOAT64: begin
               c.start_bit  = ($urandom_range(3) == 0) ? 6'($urandom) : 6'd0;
               c.bit_length = ($urandom_range(4) == 0) ? 7'($urandom) : 7'd64;
            end
            default: begin
               c.start_bit = 6'($urandom);
               case ($urandom_range(5))
                  0:       c.bit_length = 7'd0;
                  1:       c.bit_length = 7'($urandom_range(127, 65));
                  2:       c.bit_length = 7'd64;
                  default: c.bit_length = 7'($urandom_range(64, 1));
               endcase
            end
         endcase
         a = {$urandom, $urandom};
         a = a >>> $urandom_range(40, 16);
         b = {$urandom, $urandom};
         b = b >>> $urandom_range(40, 16);
         case ($urandom_range(4))
            0, 1: ;                                      // full range
            2: begin
               c.clamp_min = (a < b) ? a : b;
               c.clamp_max = (a < b) ? b : a;
            end
            3: begin                                     // crossed
               c.clamp_min = (a < b) ? b : a;
               c.clamp_max = (a < b) ? a : b;
            end
            default: begin
               c.clamp_min = {$urandom, $urandom};
               c.clamp_max = {$urandom, $urandom};
            end
         endcase
         case ($urandom_range(6))
            0: c.factor = 32'sh7FFF_FFFF;
            1: c.factor = 32'sh8000_0000;
            2: c.factor = 32'sd0;
            3: ;                                         // unity
            4: c.factor = $urandom;
            default: begin
               c.factor = $urandom;
               c.factor = c.factor >>> $urandom_range(24, 8);
            end
         endcase
         case ($urandom_range(5))
            0: c.offset = SMAX;
            1: c.offset = SMIN;
            2: c.offset = {$urandom, $urandom};
            3: c.offset = a;
            default: ;
         endcase

         // block is idle here: nothing pending and silent frames flushed
         drain_results();
         load_cfg(c, 1'b1);

         for (int n = 0; n < GROUP_ITEMS; n++) begin
            case ($urandom_range(9))
               0:       id = 29'($urandom);
               1:       id = active_cfg.frame_id ^ (29'd1 << $urandom_range(28));
               default: id = active_cfg.frame_id;
            endcase
            pl   = {$urandom, $urandom};
            sgn  = $urandom_range(1);
            frac = {$urandom, $urandom};
            if ($urandom_range(4) == 0) frac = '0;
            case (active_cfg.kind)
               SIG_FLOAT32: begin
                  case ($urandom_range(9))
                     0:       ex_f32 = 8'hFF;
                     1:       ex_f32 = 8'h00;
                     2:       ex_f32 = 8'($urandom);
                     default: ex_f32 = 8'($urandom_range(177, 107));
                  endcase
                  fld = {32'd0, sgn, ex_f32, frac[22:0]};
                  pl  = (pl & ~(64'hFFFF_FFFF << active_cfg.start_bit))
                        | (fld << active_cfg.start_bit);
               end
               SIG_FLOAT64: begin
                  case ($urandom_range(9))
                     0:       ex_f64 = 11'h7FF;
                     1:       ex_f64 = 11'h000;
                     2:       ex_f64 = 11'($urandom);
                     default: ex_f64 = 11'($urandom_range(1073, 1003));
                  endcase
                  fld = {sgn, ex_f64, frac};
                  pl  = (pl & ~({64{1'b1}} << active_cfg.start_bit))
                        | (fld << active_cfg.start_bit);
               end
               default: begin
                  // vary the count of leading zeros across the field
                  if ($urandom_range(3) == 0) pl = pl >> $urandom_range(63);
               end
            endcase
            send_frame(id, pl);
            predict_frame(id, pl);
         end
      end

      drain_results();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/csx_pkg.sv
hw/rtl/csx_extract.sv
hw/rtl/csx_to_fixed.sv
hw/rtl/csx_scale.sv
hw/rtl/can_signal_extract_scale.sv
bench/testbench.sv
